// ===== rtl/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartesian to spherical package
// Shared widths, the arctangent table and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none
package c2s_pkg;
  localparam int unsigned CoordWidthDefault = 32;
  localparam int unsigned CordicStagesDefault = 16;
  localparam int unsigned AngleWidth = 16;
  localparam int unsigned AccWidth = 32;
  localparam int unsigned MaxStages = 32;
  localparam int unsigned CordicWidth = 62;
  localparam logic [AccWidth-1:0] HalfTurn = 32'h8000_0000;
  localparam logic [AccWidth-1:0] ThreeQuarterTurn = 32'hC000_0000;

  function automatic logic [AccWidth-1:0] atan_entry(input int unsigned idx);
    logic [AccWidth-1:0] tab [MaxStages];
    tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
    return tab[idx % MaxStages];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/c2s_if.sv =====
// ----------------------------------------------------------------------------
// Cartesian to spherical channel interfaces
// Valid/ready channels for the input point and the spherical result.
// ----------------------------------------------------------------------------
`default_nettype none
interface c2s_in_if #(
  parameter int unsigned COORD_WIDTH = c2s_pkg::CoordWidthDefault
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] z_coord;
  modport source (output valid, x_coord, y_coord, z_coord, input ready);
  modport sink (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface c2s_out_if #(
  parameter int unsigned COORD_WIDTH = c2s_pkg::CoordWidthDefault
);
  logic valid;
  logic ready;
  logic [COORD_WIDTH-1:0] radius;
  logic [c2s_pkg::AngleWidth-1:0] polar_angle;
  logic [c2s_pkg::AngleWidth-1:0] azimuth;
  logic zero_vector;
  modport source (output valid, radius, polar_angle, azimuth, zero_vector, input ready);
  modport sink (input valid, radius, polar_angle, azimuth, zero_vector, output ready);
endinterface
`default_nettype wire

// ===== rtl/cartesian_to_spherical.sv =====
// ----------------------------------------------------------------------------
// Cartesian to spherical converter
// Pipeline: an input register for magnitudes and squares, the bit-per-stage square
// roots, the one-rotation-per-stage CORDICs and an output register.
// Throughput is one transfer per cycle while the output is not stalled; the whole pipeline stalls together.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module cartesian_to_spherical #(
  parameter int unsigned COORD_WIDTH = c2s_pkg::CoordWidthDefault,
  parameter int unsigned CORDIC_STAGES = c2s_pkg::CordicStagesDefault
) (
  input wire clk_i,
  input wire rst_ni,
  c2s_in_if.sink in_i,
  c2s_out_if.source out_o
);
  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned NS = (CORDIC_STAGES > c2s_pkg::MaxStages) ?
                               c2s_pkg::MaxStages : CORDIC_STAGES;
  localparam int unsigned CW = c2s_pkg::CordicWidth;
  localparam int unsigned PS = 58 - W;
  localparam int unsigned AW = c2s_pkg::AccWidth;
  localparam int unsigned RW = W + 1;
  localparam int unsigned QS = 2 * RW;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [AW-1:0] acc;
  } cord_t;

  typedef struct packed {
    logic [QS-1:0] rem;
    logic [RW-1:0] root;
  } sqrt_t;

  logic adv;
  assign adv = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // Stage 0: magnitudes and squares.
  logic v0_q;
  logic signed [W-1:0] x0_q, y0_q, z0_q;
  logic [SW-1:0] sxy0_q, szz0_q;
  logic [W:0] ax, ay, az;
  always_comb begin
    ax = in_i.x_coord[W-1] ? (W+1)'(-$signed({in_i.x_coord[W-1], in_i.x_coord}))
                           : {1'b0, in_i.x_coord};
    ay = in_i.y_coord[W-1] ? (W+1)'(-$signed({in_i.y_coord[W-1], in_i.y_coord}))
                           : {1'b0, in_i.y_coord};
    az = in_i.z_coord[W-1] ? (W+1)'(-$signed({in_i.z_coord[W-1], in_i.z_coord}))
                           : {1'b0, in_i.z_coord};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_i.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= in_i.x_coord;
      y0_q <= in_i.y_coord;
      z0_q <= in_i.z_coord;
      sxy0_q <= SW'(ax * ax) + SW'(ay * ay);
      szz0_q <= SW'(az * az);
    end
  end

  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [SW-1:0] n,
                                      input int unsigned k);
    sqrt_t r;
    logic [QS+1:0] trial;
    logic [QS-1:0] rem;
    logic [1:0] pair;
    int unsigned b;
    b = RW - 1 - k;
    pair = (2*b + 1 < SW) ? {n[2*b+1], n[2*b]} : {1'b0, (2*b < SW) ? n[2*b] : 1'b0};
    rem = {s.rem[QS-3:0], pair};
    trial = {2'b00, rem} - {QS'(s.root), 2'b01};
    if (!trial[QS+1]) begin
      r.rem = trial[QS-1:0];
      r.root = {s.root[RW-2:0], 1'b1};
    end else begin
      r.rem = rem;
      r.root = {s.root[RW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Square root pipelines: one result bit per stage, both roots in parallel.
  logic vs_q [RW+1];
  logic signed [W-1:0] xs_q [RW+1], ys_q [RW+1], zs_q [RW+1];
  sqrt_t qa_q [RW+1], qb_q [RW+1];
  logic [SW-1:0] na_q [RW+1], nb_q [RW+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= RW; k++) vs_q[k] <= 1'b0;
    end else if (adv) begin
      vs_q[0] <= v0_q;
      for (int k = 1; k <= RW; k++) vs_q[k] <= vs_q[k-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xs_q[0] <= x0_q;
      ys_q[0] <= y0_q;
      zs_q[0] <= z0_q;
      na_q[0] <= sxy0_q;
      nb_q[0] <= sxy0_q + szz0_q;
      qa_q[0] <= '0;
      qb_q[0] <= '0;
      for (int k = 1; k <= RW; k++) begin
        xs_q[k] <= xs_q[k-1];
        ys_q[k] <= ys_q[k-1];
        zs_q[k] <= zs_q[k-1];
        na_q[k] <= na_q[k-1];
        nb_q[k] <= nb_q[k-1];
        qa_q[k] <= sqrt_step(qa_q[k-1], na_q[k-1], k - 1);
        qb_q[k] <= sqrt_step(qb_q[k-1], nb_q[k-1], k - 1);
      end
    end
  end

  // CORDIC setup.
  logic vc_q [NS+1];
  logic zv_q [NS+1];
  logic zxy_q [NS+1];
  logic [W-1:0] rad_q [NS+1];
  cord_t ct_q [NS+1], cp_q [NS+1];
  logic [W-1:0] rxy;
  assign rxy = qa_q[RW].root[W-1:0];

  function automatic cord_t cord_init(input logic signed [CW-1:0] py,
                                      input logic signed [CW-1:0] px);
    cord_t c;
    c.acc = '0;
    if (px < 0) begin
      px = -px;
      py = -py;
      c.acc = c2s_pkg::HalfTurn;
    end
    c.px = px <<< PS;
    c.py = py <<< PS;
    return c;
  endfunction

  function automatic cord_t cord_step(input cord_t c, input int unsigned i);
    cord_t r;
    logic signed [CW-1:0] dx, dy;
    dx = c.py >>> i;
    dy = c.px >>> i;
    if (!c.py[CW-1]) begin
      r.px = c.px + dx;
      r.py = c.py - dy;
      r.acc = c.acc + c2s_pkg::atan_entry(i);
    end else begin
      r.px = c.px - dx;
      r.py = c.py + dy;
      r.acc = c.acc - c2s_pkg::atan_entry(i);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) vc_q[k] <= 1'b0;
    end else if (adv) begin
      vc_q[0] <= vs_q[RW];
      for (int k = 1; k <= NS; k++) vc_q[k] <= vc_q[k-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zv_q[0] <= (xs_q[RW] == '0) && (ys_q[RW] == '0) && (zs_q[RW] == '0);
      zxy_q[0] <= (xs_q[RW] == '0) && (ys_q[RW] == '0);
      rad_q[0] <= qb_q[RW].root[W-1:0];
      ct_q[0] <= cord_init(CW'($signed({1'b0, rxy})), CW'(zs_q[RW]));
      cp_q[0] <= cord_init(CW'(ys_q[RW]), CW'(xs_q[RW]));
      for (int k = 1; k <= NS; k++) begin
        zv_q[k] <= zv_q[k-1];
        zxy_q[k] <= zxy_q[k-1];
        rad_q[k] <= rad_q[k-1];
        ct_q[k] <= cord_step(ct_q[k-1], k - 1);
        cp_q[k] <= cord_step(cp_q[k-1], k - 1);
      end
    end
  end

  // Output register with clamping and rounding.
  logic [AW-1:0] th, th_r, ph_r;
  always_comb begin
    th = ct_q[NS].acc;
    if (th >= c2s_pkg::ThreeQuarterTurn) begin
      th = '0;
    end else if (th > c2s_pkg::HalfTurn) begin
      th = c2s_pkg::HalfTurn;
    end
    th_r = th + AW'(32'h8000);
    ph_r = cp_q[NS].acc + AW'(32'h8000);
  end
  logic ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= vc_q[NS];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_o.zero_vector <= zv_q[NS];
      out_o.radius <= zv_q[NS] ? '0 : rad_q[NS];
      out_o.polar_angle <= zv_q[NS] ? '0 : th_r[AW-1:AW-16];
      out_o.azimuth <= zxy_q[NS] ? '0 : ph_r[AW-1:AW-16];
    end
  end
  assign out_o.valid = ov_q;
endmodule
`default_nettype wire

// ===== tb/sv/tb_c2s_if.sv =====
// ----------------------------------------------------------------------------
// Cartesian to spherical testbench channel helpers
// Types that describe one point and one expected spherical result.
// ----------------------------------------------------------------------------
package tb_c2s_types_pkg;
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic [31:0] radius;
    logic [15:0] polar_angle;
    logic [15:0] azimuth;
    logic zero_vector;
  } sphere_t;
endpackage

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Cartesian to spherical testbench
// Drives directed and random points through the converter with random idle
// cycles on both channels and checks every result against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
  localparam int Latency = 53;
  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  c2s_in_if #(.COORD_WIDTH(32)) in_ch ();
  c2s_out_if #(.COORD_WIDTH(32)) out_ch ();

  cartesian_to_spherical u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #4 clk_i = ~clk_i;

  tb_c2s_types_pkg::point_t pending_points[$];
  tb_c2s_types_pkg::sphere_t expected_spheres[$];
  bit no_idle = 1'b0;
  bit failed = 1'b0;
  bit stim_done = 1'b0;
  bit hold_send = 1'b0;
  int quiet_cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] vector_angle(logic signed [63:0] py,
                                               logic signed [63:0] px);
    logic [31:0] acc;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    acc = '0;
    if (px == 0 && py == 0) return '0;
    if (px < 0) begin
      px = -px;
      py = -py;
      acc = c2s_pkg::HalfTurn;
    end
    px = px <<< 26;
    py = py <<< 26;
    for (int i = 0; i < 16; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px += dx;
        py -= dy;
        acc += c2s_pkg::atan_entry(i);
      end else begin
        px -= dx;
        py += dy;
        acc -= c2s_pkg::atan_entry(i);
      end
    end
    return acc;
  endfunction

  function automatic tb_c2s_types_pkg::sphere_t convert_point(tb_c2s_types_pkg::point_t p);
    tb_c2s_types_pkg::sphere_t s;
    logic [127:0] ax2;
    logic [127:0] ay2;
    logic [127:0] az2;
    logic [63:0] rxy;
    logic [31:0] th;
    logic [31:0] ph;
    logic [32:0] rnd;
    if (p.x == 0 && p.y == 0 && p.z == 0) return '{0, 0, 0, 1'b1};
    ax2 = 128'(longint'(p.x) * longint'(p.x));
    ay2 = 128'(longint'(p.y) * longint'(p.y));
    az2 = 128'(longint'(p.z) * longint'(p.z));
    rxy = int_sqrt(ax2 + ay2);
    s.radius = 32'(int_sqrt(ax2 + ay2 + az2));
    th = vector_angle(signed'(rxy), 64'(p.z));
    if (th >= c2s_pkg::ThreeQuarterTurn) th = '0;
    else if (th > c2s_pkg::HalfTurn) th = c2s_pkg::HalfTurn;
    ph = vector_angle(64'(p.y), 64'(p.x));
    rnd = {1'b0, th} + 33'h8000;
    s.polar_angle = rnd[31:16];
    rnd = {1'b0, ph} + 33'h8000;
    s.azimuth = rnd[31:16];
    s.zero_vector = 1'b0;
    return s;
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      3: return 32'(0);
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom) >>> $urandom_range(0, 31));
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      void'(pending_points.pop_front());
      expected_spheres.push_back(convert_point({in_ch.x_coord, in_ch.y_coord,
                                                in_ch.z_coord}));
    end
    if (!hold_send && pending_points.size() > 0 &&
        (no_idle || $urandom_range(0, 99) >= 26) &&
        !(in_ch.valid && !in_ch.ready)) begin
      in_ch.valid <= 1'b1;
      {in_ch.x_coord, in_ch.y_coord, in_ch.z_coord} <= pending_points[0];
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    tb_c2s_types_pkg::sphere_t want;
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 26);
    if (out_ch.valid && out_ch.ready) begin
      if (expected_spheres.size() == 0) begin
        $error("unexpected result transfer");
        failed = 1'b1;
      end else begin
        want = expected_spheres.pop_front();
        if (out_ch.radius !== want.radius) begin
          $error("radius expected %0d actual %0d", want.radius, out_ch.radius);
          failed = 1'b1;
        end
        if (out_ch.polar_angle !== want.polar_angle) begin
          $error("polar_angle expected %0d actual %0d", want.polar_angle,
                 out_ch.polar_angle);
          failed = 1'b1;
        end
        if (out_ch.azimuth !== want.azimuth) begin
          $error("azimuth expected %0d actual %0d", want.azimuth, out_ch.azimuth);
          failed = 1'b1;
        end
        if (out_ch.zero_vector !== want.zero_vector) begin
          $error("zero_vector expected %0d actual %0d", want.zero_vector,
                 out_ch.zero_vector);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] extremes[6];
    in_ch.valid = 1'b0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.z_coord = '0;
    out_ch.ready = 1'b0;
    extremes = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                 32'hFFFF_0000, 32'hFFFF_FFFF};
    hold_send = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_points.push_back('{0, 0, 0});
    pending_points.push_back('{0, 0, 32'h0001_0000});
    pending_points.push_back('{0, 0, 32'hFFFF_0000});
    pending_points.push_back('{32'hFFFF_0000, 0, 0});
    pending_points.push_back('{32'hFFFF_0000, 32'hFFFF_FFFF, 0});
    pending_points.push_back('{32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF});
    pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_points.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    for (int i = 0; i < 14; i++)
      pending_points.push_back('{extremes[$urandom_range(0, 5)],
                                 extremes[$urandom_range(0, 5)],
                                 extremes[$urandom_range(0, 5)]});
    for (int i = 0; i < 1550; i++)
      pending_points.push_back('{random_coord(), random_coord(), random_coord()});
    @(posedge clk_i);
    hold_send <= 1'b0;
    wait (pending_points.size() < 1200);
    hold_send <= 1'b1;
    wait (!in_ch.valid && expected_spheres.size() == 0);
    @(posedge clk_i);
    hold_send <= 1'b0;
    no_idle <= 1'b1;
    wait (pending_points.size() < 800);
    no_idle <= 1'b0;
    wait (pending_points.size() == 0 && !in_ch.valid);
    wait (expected_spheres.size() == 0);
    repeat (Latency + 20) @(posedge clk_i);
    if (!failed && expected_spheres.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
